/* rtl/core/cmphh_pkg.sv */
`timescale 1ns / 1ps

package cmphh_pkg;

    localparam int ROWS        = 4;
    localparam int COLUMNS     = 512;
    localparam int COUNT_WIDTH = 32;

    localparam int IDX_W       = $clog2(COLUMNS);
    localparam int PREFIX_W    = 24;
    localparam int ADDR_W      = 32;
    localparam int OUT_W       = 32;
    localparam int LOW_BITS    = ADDR_W - PREFIX_W;
    localparam int FOLD_SHIFT  = 33;
    localparam int SH_W        = FOLD_SHIFT + IDX_W;
    localparam int PROD_W      = SH_W - LOW_BITS;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [63:0] GOLDEN_MUL = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [OUT_W-1:0] TOTAL_MAX = '1;

    localparam logic [3:0][31:0] ROW_SEED = {
        32'hDEAD_BEEF, 32'hCAFE_BABE, 32'h5A5A_5A5A, 32'hA5A5_A5A5
    };

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef logic [ROWS-1:0][IDX_W-1:0] t_idx_vec;

    typedef struct packed {
        logic                action;
        logic [PREFIX_W-1:0] prefix;
        t_idx_vec            idx;
    } t_job;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_UPDATE,
        S_MIN,
        S_TRACK,
        S_EMIT
    } t_state;

endpackage

/* rtl/core/count_min_prefix_heavy_hitter.sv */
`timescale 1ns / 1ps
// The back end runs one item at a time: an insert passes through pop with
// counter read, increment and write, minimum, top compare and emit.
// A clear emits its zero result and then sweeps the counter memory, one column
// of all rows per cycle, through all 512 columns. After reset the same sweep
// runs before the first item is taken from the queue; input beats queue up.
module count_min_prefix_heavy_hitter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_action,
    input  logic [cmphh_pkg::ADDR_W-1:0]   i_src_address,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [cmphh_pkg::OUT_W-1:0]    o_min_count,
    output logic [cmphh_pkg::PREFIX_W-1:0] o_top_prefix,
    output logic [cmphh_pkg::OUT_W-1:0]    o_top_count,
    output logic [cmphh_pkg::OUT_W-1:0]    o_total_count
);
    import cmphh_pkg::*;

    t_job w_push_job;
    t_job w_head_job;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_head_valid;

    cmphh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_src_address (i_src_address),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    cmphh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_job   (w_head_job)
    );

    cmphh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_head_valid),
        .i_job         (w_head_job),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_min_count   (o_min_count),
        .o_top_prefix  (o_top_prefix),
        .o_top_count   (o_top_count),
        .o_total_count (o_total_count)
    );

endmodule

/* rtl/core/cmphh_front.sv */
`timescale 1ns / 1ps

module cmphh_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic [cmphh_pkg::ADDR_W-1:0] i_src_address,
    input  logic                         i_full,
    output logic                         o_push,
    output cmphh_pkg::t_job              o_job
);
    import cmphh_pkg::*;

    logic                r_v;
    logic                r_action;
    logic [PREFIX_W-1:0] r_prefix;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   n_prod;
    logic [SH_W-1:0]     w_sh;

    assign o_ready = !r_v || !i_full;
    assign o_push  = r_v && !i_full;

    assign n_prod = PROD_W'({{(PROD_W-PREFIX_W){1'b0}}, i_src_address[ADDR_W-1:LOW_BITS]}
                            * GOLDEN_MUL[PROD_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_action <= i_action;
            r_prefix <= i_src_address[ADDR_W-1:LOW_BITS];
            r_prod   <= n_prod;
        end
    end

    assign w_sh = {r_prod, {LOW_BITS{1'b0}}};

    always_comb begin
        o_job.action = r_action;
        o_job.prefix = r_prefix;
        for (int r = 0; r < ROWS; r++) begin
            o_job.idx[r] = w_sh[IDX_W-1:0] ^ ROW_SEED[r][IDX_W-1:0]
                           ^ w_sh[SH_W-1:FOLD_SHIFT];
        end
    end

endmodule

/* rtl/core/cmphh_queue.sv */
`timescale 1ns / 1ps

module cmphh_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmphh_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cmphh_pkg::t_job o_job
);
    import cmphh_pkg::*;

    t_job              r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* rtl/core/cmphh_back.sv */
`timescale 1ns / 1ps

module cmphh_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    input  cmphh_pkg::t_job                i_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [cmphh_pkg::OUT_W-1:0]    o_min_count,
    output logic [cmphh_pkg::PREFIX_W-1:0] o_top_prefix,
    output logic [cmphh_pkg::OUT_W-1:0]    o_top_count,
    output logic [cmphh_pkg::OUT_W-1:0]    o_total_count
);
    import cmphh_pkg::*;

    logic [COUNT_WIDTH-1:0] r_mem [ROWS][COLUMNS];
    logic [COUNT_WIDTH-1:0] r_rd  [ROWS];
    logic [COUNT_WIDTH-1:0] r_cnt [ROWS];
    logic [COUNT_WIDTH-1:0] n_cnt [ROWS];

    t_state                 r_state;
    t_state                 n_state;
    logic [IDX_W-1:0]       r_sweep_addr;
    t_idx_vec               r_idx;
    logic [PREFIX_W-1:0]    r_prefix;
    logic                   r_is_clear;
    logic [COUNT_WIDTH-1:0] r_est;
    logic [COUNT_WIDTH-1:0] n_est;
    logic [OUT_W-1:0]       r_total;
    logic [PREFIX_W-1:0]    r_top_prefix;
    logic [COUNT_WIDTH-1:0] r_top_count;
    logic                   r_out_valid;

    logic w_sweep_done;
    logic w_out_free;
    logic w_load;
    logic w_mem_we;

    assign w_sweep_done = (r_sweep_addr == IDX_W'(COLUMNS - 1));
    assign w_out_free   = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP:  if (w_sweep_done) n_state = S_IDLE;
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.action == ACT_CLEAR) ? S_EMIT : S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_MIN;
            S_MIN:    n_state = S_TRACK;
            S_TRACK:  n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = r_is_clear ? S_SWEEP : S_IDLE;
                end
            end
            default:  n_state = S_SWEEP;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        w_load   = 1'b0;
        w_mem_we = 1'b0;
        unique case (r_state)
            S_SWEEP:  w_mem_we = 1'b1;
            S_IDLE:   o_pop    = i_job_valid;
            S_UPDATE: w_mem_we = 1'b1;
            S_EMIT:   w_load   = w_out_free;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            n_cnt[r] = (r_rd[r] == COUNT_MAX) ? r_rd[r] : r_rd[r] + 1'b1;
        end
        n_est = r_cnt[0];
        for (int r = 1; r < ROWS; r++) begin
            if (r_cnt[r] < n_est) begin
                n_est = r_cnt[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < ROWS; r++) begin
            if (w_mem_we) begin
                if (r_state == S_SWEEP) begin
                    r_mem[r][r_sweep_addr] <= '0;
                end else begin
                    r_mem[r][r_idx[r]] <= n_cnt[r];
                end
            end
            r_rd[r] <= r_mem[r][i_job.idx[r]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
            r_total      <= '0;
            r_top_prefix <= '0;
            r_top_count  <= '0;
            r_is_clear   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SWEEP) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end
            if (o_pop) begin
                r_is_clear <= (i_job.action == ACT_CLEAR);
                if (i_job.action == ACT_CLEAR) begin
                    r_total      <= '0;
                    r_top_prefix <= '0;
                    r_top_count  <= '0;
                end
            end
            if (r_state == S_UPDATE && r_total != TOTAL_MAX) begin
                r_total <= r_total + 1'b1;
            end
            if (r_state == S_TRACK && r_est > r_top_count) begin
                r_top_prefix <= r_prefix;
                r_top_count  <= r_est;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_idx    <= i_job.idx;
            r_prefix <= i_job.prefix;
            r_est    <= '0;
        end
        if (r_state == S_UPDATE) begin
            for (int r = 0; r < ROWS; r++) begin
                r_cnt[r] <= n_cnt[r];
            end
        end
        if (r_state == S_MIN) begin
            r_est <= n_est;
        end
        if (w_load) begin
            o_min_count   <= OUT_W'(r_est);
            o_top_prefix  <= r_top_prefix;
            o_top_count   <= OUT_W'(r_top_count);
            o_total_count <= r_total;
        end
    end

    assign o_valid = r_out_valid;

endmodule

/* rtl/core/cmphh_checker.sv */
`timescale 1ns / 1ps

module cmphh_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  logic [cmphh_pkg::OUT_W-1:0]    o_min_count,
    input  logic [cmphh_pkg::PREFIX_W-1:0] o_top_prefix,
    input  logic [cmphh_pkg::OUT_W-1:0]    o_top_count,
    input  logic [cmphh_pkg::OUT_W-1:0]    o_total_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_min_count) && $stable(o_top_count)
            && $stable(o_top_prefix) && $stable(o_total_count))
        else $error("Result beat changed while stalled.");

    a_min_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_min_count <= o_top_count)
        else $error("Estimate exceeds the tracked top count.");

    a_top_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_top_count <= o_total_count)
        else $error("Top count exceeds the insert total.");

    a_zero_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_top_count == '0 |-> o_top_prefix == '0)
        else $error("Top prefix set without a count.");

    a_zero_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_min_count == '0 |-> o_total_count == '0)
        else $error("Zero estimate on an insert.");

endmodule

bind count_min_prefix_heavy_hitter cmphh_checker u_checker (.*);

/* tb/count_min_prefix_heavy_hitter_test.sv */
`timescale 1ns / 1ps

module count_min_prefix_heavy_hitter_test;

    import cmphh_pkg::*;

    localparam int RANDOM_ITEMS = 630;
    localparam int HOT_SLOTS    = 6;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 300;

    localparam logic [63:0]       GOLDEN_RATIO = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [3:0][31:0]  ROW_SALT     = {
        32'hDEAD_BEEF, 32'hCAFE_BABE, 32'h5A5A_5A5A, 32'hA5A5_A5A5
    };
    localparam logic [ADDR_W-1:0]      PREFIX_KEEP = 32'hFFFF_FF00;
    localparam int                     FOLD_BITS   = 33;
    localparam logic [COUNT_WIDTH-1:0] CELL_FULL   = '1;
    localparam logic [OUT_W-1:0]       TOTAL_FULL  = '1;

    typedef struct {
        logic [OUT_W-1:0]    min_count;
        logic [PREFIX_W-1:0] top_prefix;
        logic [OUT_W-1:0]    peak_count;
        logic [OUT_W-1:0]    total_count;
    } t_tally;

    typedef struct {
        logic              act;
        logic [ADDR_W-1:0] addr;
        bit                known;
        t_tally            want;
    } t_plan_row;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                i_action      = ACT_INSERT;
    logic [ADDR_W-1:0]   i_src_address = '0;
    logic                i_ready       = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [OUT_W-1:0]    o_min_count;
    logic [PREFIX_W-1:0] o_top_prefix;
    logic [OUT_W-1:0]    o_top_count;
    logic [OUT_W-1:0]    o_total_count;

    logic [COUNT_WIDTH-1:0] sketch_cells [ROWS][COLUMNS];
    logic [OUT_W-1:0]       seen_total;
    logic [PREFIX_W-1:0]    heavy_prefix;
    logic [OUT_W-1:0]       heavy_count;

    t_tally    pending_tallies [$];
    t_plan_row directed_plan [$];
    int        mismatch_count = 0;
    int        results_seen   = 0;
    bit        sender_quiet   = 1'b0;

    count_min_prefix_heavy_hitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_src_address (i_src_address),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_min_count   (o_min_count),
        .o_top_prefix  (o_top_prefix),
        .o_top_count   (o_top_count),
        .o_total_count (o_total_count)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [IDX_W-1:0] sketch_column(logic [ADDR_W-1:0] key, int row);
        logic [63:0] mix;
        mix = {32'd0, key} * GOLDEN_RATIO;
        mix = mix ^ {32'd0, ROW_SALT[row]};
        mix = mix ^ (mix >> FOLD_BITS);
        return IDX_W'(mix[31:0] % 32'(COLUMNS));
    endfunction

    function automatic void clear_sketch();
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                sketch_cells[r][c] = '0;
            end
        end
        seen_total   = '0;
        heavy_prefix = '0;
        heavy_count  = '0;
    endfunction

    function automatic t_tally predict_tally(logic act, logic [ADDR_W-1:0] addr);
        t_tally                 t;
        logic [ADDR_W-1:0]      key;
        logic [COUNT_WIDTH-1:0] bucket;
        logic [OUT_W-1:0]       estimate;
        logic [IDX_W-1:0]       col;
        estimate = '0;
        if (act == ACT_CLEAR) begin
            clear_sketch();
        end else begin
            key = addr & PREFIX_KEEP;
            for (int r = 0; r < ROWS; r++) begin
                col    = sketch_column(key, r);
                bucket = sketch_cells[r][col];
                if (bucket != CELL_FULL) begin
                    bucket = bucket + 1'b1;
                end
                sketch_cells[r][col] = bucket;
                if (r == 0 || OUT_W'(bucket) < estimate) begin
                    estimate = OUT_W'(bucket);
                end
            end
            if (seen_total != TOTAL_FULL) begin
                seen_total = seen_total + 1'b1;
            end
            // A tie with the stored heavy count keeps the old prefix.
            if (estimate > heavy_count) begin
                heavy_prefix = key[ADDR_W-1:ADDR_W-PREFIX_W];
                heavy_count  = estimate;
            end
        end
        t.min_count   = estimate;
        t.top_prefix  = heavy_prefix;
        t.peak_count  = heavy_count;
        t.total_count = seen_total;
        return t;
    endfunction

    task automatic plan(input logic act, input logic [ADDR_W-1:0] addr, input bit known,
                        input logic [OUT_W-1:0] want_min, input logic [PREFIX_W-1:0] want_prefix,
                        input logic [OUT_W-1:0] want_top, input logic [OUT_W-1:0] want_total);
        t_plan_row row;
        row.act              = act;
        row.addr             = addr;
        row.known            = known;
        row.want.min_count   = want_min;
        row.want.top_prefix  = want_prefix;
        row.want.peak_count  = want_top;
        row.want.total_count = want_total;
        directed_plan.push_back(row);
    endtask

    task automatic offer_beat(input logic act, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_src_address <= addr;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin : stimulus
        t_tally              t;
        logic                act;
        logic [ADDR_W-1:0]   addr;
        logic [PREFIX_W-1:0] hot_prefixes [HOT_SLOTS];
        int                  pick;
        int                  slot;

        clear_sketch();
        plan(ACT_INSERT, 32'h0000_0000, 1, 1, 24'h000000, 1, 1);
        plan(ACT_INSERT, 32'h0000_00FF, 1, 2, 24'h000000, 2, 2);
        plan(ACT_INSERT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        plan(ACT_INSERT, 32'hFFFF_FF00, 0, 0, 0, 0, 0);
        plan(ACT_INSERT, 32'hFFFF_FF7F, 0, 0, 0, 0, 0);
        plan(ACT_CLEAR,  32'hFFFF_FFFF, 1, 0, 24'h000000, 0, 0);
        plan(ACT_CLEAR,  32'h0000_0000, 1, 0, 24'h000000, 0, 0);
        plan(ACT_INSERT, 32'h8000_0000, 1, 1, 24'h800000, 1, 1);
        plan(ACT_INSERT, 32'h8000_00AB, 1, 2, 24'h800000, 2, 2);
        plan(ACT_INSERT, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        plan(ACT_INSERT, 32'hAAAA_AAAA, 0, 0, 0, 0, 0);
        plan(ACT_INSERT, 32'h5555_5555, 0, 0, 0, 0, 0);
        plan(ACT_INSERT, 32'h7FFF_FF80, 0, 0, 0, 0, 0);
        plan(ACT_INSERT, 32'h7FFF_FF01, 0, 0, 0, 0, 0);
        plan(ACT_INSERT, 32'hAAAA_AA00, 0, 0, 0, 0, 0);
        plan(ACT_INSERT, 32'h0A0B_0C0D, 0, 0, 0, 0, 0);
        plan(ACT_INSERT, 32'h0102_0304, 0, 0, 0, 0, 0);
        plan(ACT_CLEAR,  32'h1234_5678, 1, 0, 24'h000000, 0, 0);
        plan(ACT_INSERT, 32'h0000_0001, 1, 1, 24'h000000, 1, 1);
        plan(ACT_INSERT, 32'hFFFF_FF80, 0, 0, 0, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[k]) begin
            offer_beat(directed_plan[k].act, directed_plan[k].addr);
            t = predict_tally(directed_plan[k].act, directed_plan[k].addr);
            if (directed_plan[k].known) begin
                t = directed_plan[k].want;
            end
            pending_tallies.push_back(t);
        end

        // A few prefixes carry most of the traffic so counts climb and the
        // heavy hitter changes hands; the first slot is the busiest.
        for (int s = 0; s < HOT_SLOTS; s++) begin
            hot_prefixes[s] = PREFIX_W'($urandom);
        end
        hot_prefixes[1] = '1;
        hot_prefixes[2] = '0;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_quiet = (n >= 150 && n < 250);
            if (n == 320) begin
                i_valid <= 1'b0;
                while (pending_tallies.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                act  = ACT_CLEAR;
                addr = $urandom;
            end else if (pick < 64) begin
                act  = ACT_INSERT;
                slot = $urandom_range(0, 1) ? 0 : $urandom_range(0, HOT_SLOTS - 1);
                addr = {hot_prefixes[slot], 8'($urandom)};
            end else begin
                act  = ACT_INSERT;
                addr = $urandom;
            end
            offer_beat(act, addr);
            pending_tallies.push_back(predict_tally(act, addr));
        end

        i_valid <= 1'b0;
        while (pending_tallies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("count_min_prefix_heavy_hitter_test: clean");
        end else begin
            $display("count_min_prefix_heavy_hitter_test: errors");
        end
        $finish;
    end

    initial begin : result_sink
        int     stall;
        t_tally want;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            // One long hold-off lets the block fill up and stall its input.
            if (results_seen == 100) begin
                stall = LONG_HOLD;
            end else if (results_seen >= 400 && results_seen < 480) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 4);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (pending_tallies.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display({"result beat %0d arrived with nothing expected: ",
                              "min %0d top %06h/%0d total %0d"},
                             results_seen, o_min_count, o_top_prefix, o_top_count,
                             o_total_count);
                end
                mismatch_count++;
            end else begin
                want = pending_tallies.pop_front();
                if (o_min_count !== want.min_count || o_top_prefix !== want.top_prefix ||
                    o_top_count !== want.peak_count || o_total_count !== want.total_count) begin
                    if (mismatch_count < 10) begin
                        $display("result beat %0d: expected min %0d top %06h/%0d total %0d",
                                 results_seen, want.min_count, want.top_prefix,
                                 want.peak_count, want.total_count);
                        $display("result beat %0d:      got min %0d top %06h/%0d total %0d",
                                 results_seen, o_min_count, o_top_prefix, o_top_count,
                                 o_total_count);
                    end
                    mismatch_count++;
                end
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("count_min_prefix_heavy_hitter_test: errors");
        $finish;
    end

endmodule
